### hdl/framed_uart_receive_parser_top_assert.svh
// Assertion macros for the framed receive parser.
// Included by the top level; relies on the clock and reset ports in scope.
`ifndef FRAMED_UART_RECEIVE_PARSER_TOP_ASSERT_SVH
`define FRAMED_UART_RECEIVE_PARSER_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define FUP_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define FUP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/fup_pkg.sv
// Package for the framed receive parser: parse phases, codes, reset values
// and the CRC16-CCITT byte update. No dependencies.
`default_nettype none

package fup_pkg;

   localparam int ByteW    = 8;
   localparam int CrcW     = 16;
   localparam int CsrIdxW  = 3;
   localparam int StatusW  = 2;

   localparam logic [CrcW-1:0] CrcInit = 16'hFFFF;
   localparam logic [CrcW-1:0] CrcPoly = 16'h1021;
   localparam logic [CrcW-1:0] CrcMsb  = 16'h8000;

   // Configuration register indexes
   localparam logic [CsrIdxW-1:0] CSR_MAX_PAYLOAD = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_START_FIRST = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_START_SECOND = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_END_FIRST   = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_END_SECOND  = 3'd4;

   // Register reset values
   localparam logic [ByteW-1:0] MaxPayloadRst  = 8'd255;
   localparam logic [ByteW-1:0] StartFirstRst  = 8'hAA;
   localparam logic [ByteW-1:0] StartSecondRst = 8'h55;
   localparam logic [ByteW-1:0] EndFirstRst    = 8'h0D;
   localparam logic [ByteW-1:0] EndSecondRst   = 8'h0A;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   localparam logic [StatusW-1:0] STATUS_GOOD     = 2'd0;
   localparam logic [StatusW-1:0] STATUS_CRC_BAD  = 2'd1;
   localparam logic [StatusW-1:0] STATUS_END_BAD  = 2'd2;
   localparam logic [StatusW-1:0] STATUS_OVERFLOW = 2'd3;

   typedef enum logic [3:0] {
      PH_HUNT0   = 4'd0,
      PH_HUNT1   = 4'd1,
      PH_LEN     = 4'd2,
      PH_CMD     = 4'd3,
      PH_PAYLOAD = 4'd4,
      PH_CRCLO   = 4'd5,
      PH_CRCHI   = 4'd6,
      PH_END0    = 4'd7,
      PH_END1    = 4'd8
   } phase_type;

   // One byte of CRC16-CCITT, MSB first
   function automatic logic [CrcW-1:0] crc_step(input logic [CrcW-1:0] crc,
                                                input logic [ByteW-1:0] b);
      logic [CrcW-1:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < ByteW; k++) begin
         if ((c & CrcMsb) != '0) begin
            c = {c[CrcW-2:0], 1'b0} ^ CrcPoly;
         end else begin
            c = {c[CrcW-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

### hdl/framed_uart_receive_parser_top.sv
// Framed receive parser top level: byte input stage, frame parser with
// CRC16-CCITT check, result register. Depends on fup_pkg and the assert header.
`default_nettype none

// One received byte is taken per cycle while req_ready is high: a byte
// accepted on req_ is held in the input register, parsed in a single pass
// (phase decode, one-byte CRC update, mark and CRC compares) and, if it
// causes a result, lands in the result register when that is free. The
// frame is mark, mark, length, command, payload, CRC low, CRC
// high, end mark, end mark. Payload bytes below max_payload come out as
// payload results (item_kind 0); every frame that reaches its end marks,
// or fails at the first one, closes with one status result (item_kind 1):
// bad end mark, then CRC mismatch, then overflow, then good. req_ready only
// drops when both the input register and the result register are full and
// the result is not drained in that cycle.
// Configuration writes through csr_ take effect at once; indexes beyond
// the five registers are ignored.

module framed_uart_receive_parser_top (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_ready,
   input  wire  [fup_pkg::ByteW-1:0]  req_rx_byte,
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output logic                       rsp_item_kind,
   output logic [fup_pkg::ByteW-1:0]  rsp_payload_byte,
   output logic [fup_pkg::ByteW-1:0]  rsp_payload_index,
   output logic [fup_pkg::ByteW-1:0]  rsp_command_code,
   output logic [fup_pkg::ByteW-1:0]  rsp_frame_length,
   output logic [fup_pkg::StatusW-1:0] rsp_frame_status,
   input  wire                        csr_we,
   input  wire  [fup_pkg::CsrIdxW-1:0] csr_index,
   input  wire  [fup_pkg::ByteW-1:0]  csr_wdata
);
   import fup_pkg::*;

   `include "framed_uart_receive_parser_top_assert.svh"

   // configuration
   logic [ByteW-1:0] max_payload_ff, start_first_ff, start_second_ff;
   logic [ByteW-1:0] end_first_ff, end_second_ff;

   // input stage
   logic             in_valid_ff;
   logic [ByteW-1:0] in_byte_ff;

   // parse state
   phase_type        phase_ff, phase_in;
   logic [ByteW-1:0] len_ff, len_in;
   logic [ByteW-1:0] cmd_ff, cmd_in;
   logic [ByteW-1:0] pos_ff, pos_in;
   logic [CrcW-1:0]  crc_ff, crc_in;
   logic [ByteW-1:0] crc_lo_ff, crc_lo_in;
   logic             crc_ok_ff, crc_ok_in;

   // result register
   logic               rsp_valid_ff;
   logic               kind_ff, kind_in;
   logic [ByteW-1:0]   pbyte_ff, pbyte_in;
   logic [ByteW-1:0]   pindex_ff, pindex_in;
   logic [ByteW-1:0]   rcmd_ff, rlen_ff;
   logic [StatusW-1:0] status_ff, status_in;

   logic out_free, proc_en, emit;
   logic [CrcW-1:0] crc_upd;
   logic [ByteW-1:0] pos_inc;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign proc_en   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   // CRC seeds from the init value on the length byte
   assign crc_upd = crc_step((phase_ff == PH_LEN) ? CrcInit : crc_ff, in_byte_ff);
   assign pos_inc = pos_ff + 8'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff  <= MaxPayloadRst;
         start_first_ff  <= StartFirstRst;
         start_second_ff <= StartSecondRst;
         end_first_ff    <= EndFirstRst;
         end_second_ff   <= EndSecondRst;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAX_PAYLOAD:  max_payload_ff  <= csr_wdata;
            CSR_START_FIRST:  start_first_ff  <= csr_wdata;
            CSR_START_SECOND: start_second_ff <= csr_wdata;
            CSR_END_FIRST:    end_first_ff    <= csr_wdata;
            CSR_END_SECOND:   end_second_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // parse state machine
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT0;
         len_ff    <= '0;
         cmd_ff    <= '0;
         pos_ff    <= '0;
         crc_ff    <= CrcInit;
         crc_lo_ff <= '0;
         crc_ok_ff <= 1'b0;
      end else if (proc_en) begin
         phase_ff  <= phase_in;
         len_ff    <= len_in;
         cmd_ff    <= cmd_in;
         pos_ff    <= pos_in;
         crc_ff    <= crc_in;
         crc_lo_ff <= crc_lo_in;
         crc_ok_ff <= crc_ok_in;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      len_in    = len_ff;
      cmd_in    = cmd_ff;
      pos_in    = pos_ff;
      crc_in    = crc_ff;
      crc_lo_in = crc_lo_ff;
      crc_ok_in = crc_ok_ff;
      emit      = 1'b0;
      kind_in   = KIND_PAYLOAD;
      pbyte_in  = '0;
      pindex_in = '0;
      status_in = STATUS_GOOD;
      case (phase_ff)
         PH_HUNT1: begin
            phase_in = (in_byte_ff == start_second_ff) ? PH_LEN : PH_HUNT0;
         end
         PH_LEN: begin
            len_in   = in_byte_ff;
            pos_in   = '0;
            crc_in   = crc_upd;
            phase_in = PH_CMD;
         end
         PH_CMD: begin
            cmd_in   = in_byte_ff;
            crc_in   = crc_upd;
            phase_in = (len_ff != '0) ? PH_PAYLOAD : PH_CRCLO;
         end
         PH_PAYLOAD: begin
            crc_in = crc_upd;
            if (pos_ff < max_payload_ff) begin
               emit      = 1'b1;
               pbyte_in  = in_byte_ff;
               pindex_in = pos_ff;
            end
            pos_in = pos_inc;
            if (pos_inc >= len_ff) begin
               phase_in = PH_CRCLO;
            end
         end
         PH_CRCLO: begin
            crc_lo_in = in_byte_ff;
            phase_in  = PH_CRCHI;
         end
         PH_CRCHI: begin
            crc_ok_in = ({in_byte_ff, crc_lo_ff} == crc_ff);
            phase_in  = PH_END0;
         end
         PH_END0: begin
            if (in_byte_ff == end_first_ff) begin
               phase_in = PH_END1;
            end else begin
               emit      = 1'b1;
               kind_in   = KIND_STATUS;
               status_in = STATUS_END_BAD;
               phase_in  = PH_HUNT0;
            end
         end
         PH_END1: begin
            emit    = 1'b1;
            kind_in = KIND_STATUS;
            if (in_byte_ff != end_second_ff) begin
               status_in = STATUS_END_BAD;
            end else if (!crc_ok_ff) begin
               status_in = STATUS_CRC_BAD;
            end else if (len_ff > max_payload_ff) begin
               status_in = STATUS_OVERFLOW;
            end else begin
               status_in = STATUS_GOOD;
            end
            phase_in = PH_HUNT0;
         end
         default: begin
            // hunting the first start mark
            phase_in = (in_byte_ff == start_first_ff) ? PH_HUNT1 : PH_HUNT0;
         end
      endcase
   end

   // result register: refilled or drained whenever it is free
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= proc_en && emit;
      end
      if (proc_en && emit) begin
         kind_ff   <= kind_in;
         pbyte_ff  <= pbyte_in;
         pindex_ff <= pindex_in;
         rcmd_ff   <= cmd_ff;
         rlen_ff   <= len_ff;
         status_ff <= status_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_item_kind     = kind_ff;
   assign rsp_payload_byte  = pbyte_ff;
   assign rsp_payload_index = pindex_ff;
   assign rsp_command_code  = rcmd_ff;
   assign rsp_frame_length  = rlen_ff;
   assign rsp_frame_status  = status_ff;

   `FUP_ASSERT_IMPL(a_stall_only_when_full, !req_ready, in_valid_ff && rsp_valid_ff,
      "input stalled while result register free")
   `FUP_ASSERT_NEXT(a_len_then_cmd, proc_en && (phase_ff == PH_LEN), phase_ff == PH_CMD,
      "length byte not followed by command phase")
   `FUP_ASSERT_IMPL(a_payload_in_frame,
      rsp_valid_ff && (kind_ff == KIND_PAYLOAD),
      (pindex_ff < rlen_ff) && (status_ff == STATUS_GOOD),
      "payload transfer outside declared length")

endmodule

`default_nettype wire

### verif/framed_parse_tb_pkg.sv
// Testbench package for the framed receive parser: result record, CRC16-CCITT
// byte update and a scoreboard that predicts the parser's results.
// Depends on fup_pkg for phase, status, kind and register codes, reset values and CRC constants.
package framed_parse_tb_pkg;
   import fup_pkg::*;

   typedef logic [7:0] byte_queue_type[$];

   typedef struct packed {
      logic       kind;
      logic [7:0] data;
      logic [7:0] index;
      logic [7:0] command;
      logic [7:0] length;
      logic [1:0] status;
   } parse_result_type;

   // bitwise feedback form, MSB of the byte first
   function automatic logic [15:0] ccitt_update(input logic [15:0] crc,
                                                input logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ b[i];
         c  = {c[14:0], 1'b0} ^ (fb ? CrcPoly : 16'h0000);
      end
      return c;
   endfunction

   class frame_result_book;
      logic [7:0]       max_payload, start_first, start_second, end_first, end_second;
      phase_type        phase;
      logic [7:0]       length, command, position, crc_low;
      logic [15:0]      crc;
      logic             crc_ok;
      parse_result_type due_results[$];
      int               errors, payload_seen;
      int               status_seen[4];

      function new();
         max_payload  = MaxPayloadRst;
         start_first  = StartFirstRst;
         start_second = StartSecondRst;
         end_first    = EndFirstRst;
         end_second   = EndSecondRst;
         phase        = PH_HUNT0;
         length       = '0;
         command      = '0;
         position     = '0;
         crc          = CrcInit;
         crc_low      = '0;
         crc_ok       = 1'b0;
         errors       = 0;
         payload_seen = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function void write_register(input logic [2:0] idx, input logic [7:0] v);
         case (idx)
            CSR_MAX_PAYLOAD:  max_payload  = v;
            CSR_START_FIRST:  start_first  = v;
            CSR_START_SECOND: start_second = v;
            CSR_END_FIRST:    end_first    = v;
            CSR_END_SECOND:   end_second   = v;
            default: ;
         endcase
      endfunction

      function void owe_result(input logic kind, input logic [7:0] data,
                               input logic [7:0] index, input logic [1:0] status);
         parse_result_type r;
         r.kind    = kind;
         r.data    = data;
         r.index   = index;
         r.command = command;
         r.length  = length;
         r.status  = status;
         due_results.push_back(r);
      endfunction

      function void take_byte(input logic [7:0] b);
         logic [1:0] st;
         case (phase)
            PH_HUNT1: phase = (b == start_second) ? PH_LEN : PH_HUNT0;
            PH_LEN: begin
               length   = b;
               position = '0;
               crc      = ccitt_update(CrcInit, b);
               phase    = PH_CMD;
            end
            PH_CMD: begin
               command = b;
               crc     = ccitt_update(crc, b);
               phase   = (length != 0) ? PH_PAYLOAD : PH_CRCLO;
            end
            PH_PAYLOAD: begin
               crc = ccitt_update(crc, b);
               if (position < max_payload) owe_result(KIND_PAYLOAD, b, position, STATUS_GOOD);
               position = position + 8'd1;
               if (position >= length) phase = PH_CRCLO;
            end
            PH_CRCLO: begin
               crc_low = b;
               phase   = PH_CRCHI;
            end
            PH_CRCHI: begin
               crc_ok = ({b, crc_low} == crc);
               phase  = PH_END0;
            end
            PH_END0: begin
               if (b == end_first) begin
                  phase = PH_END1;
               end else begin
                  owe_result(KIND_STATUS, 8'h00, 8'h00, STATUS_END_BAD);
                  phase = PH_HUNT0;
               end
            end
            PH_END1: begin
               if (b != end_second) st = STATUS_END_BAD;
               else if (!crc_ok) st = STATUS_CRC_BAD;
               else if (length > max_payload) st = STATUS_OVERFLOW;
               else st = STATUS_GOOD;
               owe_result(KIND_STATUS, 8'h00, 8'h00, st);
               phase = PH_HUNT0;
            end
            default: phase = (b == start_first) ? PH_HUNT1 : PH_HUNT0;
         endcase
      endfunction

      function void compare_field(input string label, input logic [7:0] want,
                                  input logic [7:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
            errors++;
         end
      endfunction

      function void match_result(input parse_result_type got);
         parse_result_type want;
         if (due_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $time, got);
            errors++;
            return;
         end
         want = due_results.pop_front();
         compare_field("item_kind", 8'(want.kind), 8'(got.kind));
         compare_field("payload_byte", want.data, got.data);
         compare_field("payload_index", want.index, got.index);
         compare_field("command_code", want.command, got.command);
         compare_field("frame_length", want.length, got.length);
         compare_field("frame_status", 8'(want.status), 8'(got.status));
         if (want.kind == KIND_STATUS) status_seen[want.status]++;
         else payload_seen++;
      endfunction

      function int outstanding();
         return due_results.size();
      endfunction
   endclass

endpackage

### verif/tb_framed_uart_receive_parser_top.sv
// Self-checking testbench for framed_uart_receive_parser_top: directed and
// random framed byte streams, random stalls, register changes between phases.
// Depends on fup_pkg, framed_parse_tb_pkg and the parser RTL.
module tb_framed_uart_receive_parser_top;
   import fup_pkg::*;
   import framed_parse_tb_pkg::*;

   localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
   localparam int QUIET_LIMIT   = 4000;  // cycles without any transfer
   localparam int SETTLE_CYCLES = 6;     // covers the input and result registers

   typedef enum {END_INTACT, END_FIRST_WRONG, END_SECOND_WRONG} end_fault_type;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic [ByteW-1:0]    req_rx_byte = '0;
   logic                rsp_ready   = 1'b0;
   logic                csr_we      = 1'b0;
   logic [CsrIdxW-1:0]  csr_index   = '0;
   logic [ByteW-1:0]    csr_wdata   = '0;
   logic                req_ready;
   logic                rsp_valid;
   logic                rsp_item_kind;
   logic [ByteW-1:0]    rsp_payload_byte, rsp_payload_index;
   logic [ByteW-1:0]    rsp_command_code, rsp_frame_length;
   logic [StatusW-1:0]  rsp_frame_status;

   frame_result_book sb;
   int   send_idle_pct = 0;
   int   rsp_idle_pct  = 0;
   int   bytes_sent    = 0;
   int   frames_sent   = 0;
   int   quiet_cycles  = 0;
   logic hold_active   = 1'b0;
   event hold_start;

   framed_uart_receive_parser_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_item_kind     (rsp_item_kind),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_payload_index (rsp_payload_index),
      .rsp_command_code  (rsp_command_code),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_frame_status  (rsp_frame_status),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Both monitors sample at the edge, before this edge's drives land.
   // The result is checked ahead of the byte: a byte never causes a result
   // in the cycle it is taken, so the order only keeps things tidy.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            sb.match_result('{rsp_item_kind, rsp_payload_byte, rsp_payload_index,
                              rsp_command_code, rsp_frame_length, rsp_frame_status});
         end
         if (req_valid && req_ready) sb.take_byte(req_rx_byte);
      end
   end

   // Receiver side: random back-pressure, or a solid hold-off when asked.
   always @(posedge clock) begin
      if (hold_active) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // Hold-off is counted here so the sender keeps offering bytes meanwhile;
   // the result register fills and the parser has to stall its input.
   initial forever begin
      @(hold_start);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_active <= 1'b0;
   end

   // Watchdog: any transfer on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // One byte transfer. Valid stays up from one byte to the next unless an
   // idle gap is drawn, so back-to-back transfers happen at full rate while req_ready is high.
   task automatic send_byte(input logic [7:0] b);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   function automatic byte_queue_type random_body(input int len);
      byte_queue_type q;
      for (int i = 0; i < len; i++) q.push_back(8'($urandom));
      return q;
   endfunction

   // Full frame with the current marks; the CRC covers length, command and
   // payload and goes out low byte first. Faults corrupt the CRC and/or an
   // end mark (a wrong first end mark ends the frame there).
   task automatic drive_frame(input logic [7:0] cmd, input byte_queue_type body,
                              input bit crc_bad, input end_fault_type fault);
      logic [15:0] crc;
      logic [7:0]  len;
      len = 8'(body.size());
      crc = ccitt_update(ccitt_update(CrcInit, len), cmd);
      foreach (body[i]) crc = ccitt_update(crc, body[i]);
      if (crc_bad) crc ^= 16'($urandom_range(1, 16'hFFFF));
      send_byte(sb.start_first);
      send_byte(sb.start_second);
      send_byte(len);
      send_byte(cmd);
      foreach (body[i]) send_byte(body[i]);
      send_byte(crc[7:0]);
      send_byte(crc[15:8]);
      case (fault)
         END_FIRST_WRONG: send_byte(sb.end_first ^ 8'($urandom_range(1, 255)));
         END_SECOND_WRONG: begin
            send_byte(sb.end_first);
            send_byte(sb.end_second ^ 8'($urandom_range(1, 255)));
         end
         default: begin
            send_byte(sb.end_first);
            send_byte(sb.end_second);
         end
      endcase
      frames_sent++;
   endtask

   // Mostly well-formed frames with random content; the rest are broken
   // starts, bad CRCs, bad end marks, and line noise between frames.
   // Noise never equals the first start mark so frames are not swallowed.
   task automatic random_traffic(input int budget, input int longest);
      int             stop_at;
      int             pick;
      logic [7:0]     b;
      end_fault_type  fault;
      stop_at = bytes_sent + budget;
      while (bytes_sent < stop_at) begin
         repeat ($urandom_range(0, 2)) begin
            b = 8'($urandom);
            if (b == sb.start_first) b = ~b;
            send_byte(b);
         end
         pick = $urandom_range(99);
         if (pick < 8) begin
            send_byte(sb.start_first);
            send_byte(sb.start_second ^ 8'($urandom_range(1, 255)));
         end else begin
            if (pick < 20) fault = END_FIRST_WRONG;
            else if (pick < 32) fault = END_SECOND_WRONG;
            else fault = END_INTACT;
            drive_frame(8'($urandom), random_body($urandom_range(0, longest)),
                        $urandom_range(99) < 20, fault);
         end
      end
   endtask

   // Drop valid and let the last transfer be booked, let every
   // expected result drain, then give the pipeline time to finish bytes
   // that cause no result.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CsrIdxW-1:0] idx, input logic [7:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      sb.write_register(idx, v);
   endtask

   // New register set, written only once the parser is idle. A write to an
   // index past the last register rides along and must be ignored.
   task automatic configure(input logic [7:0] max_pl, input logic [7:0] sf,
                            input logic [7:0] ss, input logic [7:0] ef,
                            input logic [7:0] es);
      settle();
      write_csr(CSR_MAX_PAYLOAD, max_pl);
      write_csr(CSR_START_FIRST, sf);
      write_csr(CSR_START_SECOND, ss);
      write_csr(CSR_END_FIRST, ef);
      write_csr(CSR_END_SECOND, es);
      write_csr(CSR_END_SECOND + 3'($urandom_range(1, 3)), 8'($urandom));
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      byte_queue_type body;
      sb = new();
      send_idle_pct = 23;
      rsp_idle_pct  = 71;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, reset register values. A first mark repeated where the
      // second belongs drops back to hunting and is not taken as a new
      // first mark, so the trailing second mark is just noise.
      send_byte(sb.start_first);
      send_byte(sb.start_first);
      send_byte(sb.start_second);
      body = {};
      drive_frame(8'hFF, body, 1'b0, END_INTACT);      // zero length, good
      body = {8'hFF};
      drive_frame(8'h00, body, 1'b1, END_INTACT);      // CRC mismatch
      body = {};
      drive_frame(8'h80, body, 1'b1, END_FIRST_WRONG); // end mark beats CRC

      // Back-pressure: receiver holds off while frames keep coming.
      -> hold_start;
      repeat (6) drive_frame(8'($urandom), random_body($urandom_range(4, 10)),
                             1'b0, END_INTACT);
      random_traffic(240, 10);

      // Nothing forwarded, every non-empty frame with good CRC and end marks overflows; extreme marks.
      configure(8'd0, 8'h00, 8'hFF, 8'hFF, 8'h00);
      random_traffic(240, 6);

      // Swap the stall mix; small payload cap with random marks.
      send_idle_pct = 71;
      rsp_idle_pct  = 23;
      configure(8'($urandom_range(1, 12)), 8'($urandom), 8'($urandom),
                8'($urandom), 8'($urandom));
      drive_frame(8'($urandom), random_body($urandom_range(200, 254)), 1'b0, END_INTACT);
      random_traffic(160, 16);

      // No stalls; widest cap and all marks at the top value.
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      configure(8'd255, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      drive_frame(8'($urandom), random_body(255), 1'b0, END_INTACT);
      random_traffic(160, 10);

      settle();
      $display("Sent %0d bytes in %0d frames over four register sets and three stall mixes.",
               bytes_sent, frames_sent);
      $display("Checked %0d payload transfers; status good %0d, crc %0d, end %0d, overflow %0d.",
               sb.payload_seen, sb.status_seen[STATUS_GOOD], sb.status_seen[STATUS_CRC_BAD],
               sb.status_seen[STATUS_END_BAD], sb.status_seen[STATUS_OVERFLOW]);
      if (sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+hdl
hdl/fup_pkg.sv
hdl/framed_uart_receive_parser_top.sv
verif/framed_parse_tb_pkg.sv
verif/tb_framed_uart_receive_parser_top.sv
